/* src/slpl_pkg.sv */
// shared constants, register indexes and arithmetic helpers for the strain position loop
`default_nettype none
package slpl_pkg;

  localparam int JOINTS = 4;
  localparam int JIDX_W = (JOINTS > 1) ? $clog2(JOINTS) : 1;

  localparam logic [12:0] STRAIN_OFFSET = 13'd126;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_FINGER  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_SPREAD  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_FINGER = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_SPREAD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_CONST   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DEADZONE     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_COUPLING     = 3'd6;

  localparam logic [31:0] RST_GAIN_FINGER  = 32'd3277;
  localparam logic [31:0] RST_GAIN_SPREAD  = 32'd66;
  localparam logic [30:0] RST_LIMIT_FINGER = 31'd262;
  localparam logic [30:0] RST_LIMIT_SPREAD = 31'd66;
  localparam logic [31:0] RST_TIME_CONST   = 32'd19661;
  localparam logic [30:0] RST_DEADZONE     = 31'd19661;
  localparam logic [31:0] RST_COUPLING     = 32'd1638;

  localparam logic [1:0] SPREAD_JOINT = 2'd3;

  // joint index folded onto the state entries
  function automatic logic [JIDX_W-1:0] slot_of(input logic [1:0] joint);
    int v;
    v = int'(joint);
    for (int i = 0; i < 4; i++) begin
      if (v >= JOINTS) begin
        v = v - JOINTS;
      end
    end
    return JIDX_W'(v);
  endfunction

  // product / 2^16, rounded half away from zero
  function automatic logic signed [49:0] round_q16(input logic signed [65:0] p);
    logic [65:0] mag;
    logic [65:0] sum;
    logic [49:0] q;
    mag = p[65] ? (66'd0 - p) : p;
    sum = mag + 66'd32768;
    q   = sum[65:16];
    return p[65] ? signed'(50'd0 - q) : signed'(q);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    logic signed [49:0] hi;
    logic signed [49:0] lo;
    hi = 50'sh0_0000_7FFF_FFFF;
    lo = -50'sh0_0000_8000_0000;
    if (v > hi) begin
      return 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      return 32'sh8000_0000;
    end else begin
      return v[31:0];
    end
  endfunction

endpackage
`default_nettype wire

/* src/slpl_mul.sv */
// shared signed 33x33 multiplier with registered product
`default_nettype none
module slpl_mul
  import slpl_pkg::*;
(
  input  wire logic               clk,
  input  wire logic signed [32:0] op_a,
  input  wire logic signed [32:0] op_b,
  output logic signed [65:0]      prod_r
);

  logic signed [65:0] prod_nxt;

  assign prod_nxt = op_a * op_b;

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule
`default_nettype wire

/* src/slpl_div.sv */
// serial restoring divider, 64-bit dividend by 33-bit divisor, one quotient bit per cycle
`default_nettype none
module slpl_div
  import slpl_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] dividend,
  input  wire logic [32:0] divisor,
  output logic             done_r,
  output logic [63:0]      quo_r
);

  logic        busy_r, busy_nxt;
  logic        done_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [63:0] num_r, num_nxt;
  logic [63:0] quo_nxt;
  logic [32:0] dsr_r, dsr_nxt;
  logic [33:0] trial;
  logic [33:0] diff;

  assign trial = {rem_r, num_r[63]};
  assign diff  = trial - {1'b0, dsr_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    num_nxt  = num_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      num_nxt  = dividend;
      quo_nxt  = '0;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      num_nxt = {num_r[62:0], 1'b0};
      if (!diff[33]) begin
        rem_nxt = diff[32:0];
        quo_nxt = {quo_r[62:0], 1'b1};
      end else begin
        rem_nxt = trial[32:0];
        quo_nxt = {quo_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd63) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    num_r <= num_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
  end

endmodule
`default_nettype wire

/* src/strain_compensated_position_loop_core.sv */
// top level: sequencer, settings, per-joint filter state and output register
//
//  channel | dir | handshake             | fields
//  in_     | in  | in_valid / in_stall   | joint, desired_pos, measured_pos, strain_raw, elapsed
//  out_    | out | out_valid / out_stall | joint_out, velocity_cmd, strain_filtered
//  cfg_    | in  | cfg_we                | cfg_index, cfg_wdata
//
// a word accepted in idle has its result loaded into the output register after the serial
// divider in the low-pass has run; when tc+dt is zero the divide is skipped. the
// products go one at a time through the shared multiplier. reset clears the settings
// to defaults and the filter state to zero. a new word is taken in the cycle after the
// output load, even while the previous result still waits under out_stall; the sequencer
// only holds before its output load until the output register is free.
`default_nettype none
module strain_compensated_position_loop_core
  import slpl_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [1:0]           in_joint,
  input  wire logic signed [31:0]   in_desired_pos,
  input  wire logic signed [31:0]   in_measured_pos,
  input  wire logic [11:0]          in_strain_raw,
  input  wire logic [31:0]          in_elapsed,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [1:0]                out_joint_out,
  output logic signed [31:0]        out_velocity_cmd,
  output logic signed [31:0]        out_strain_filtered,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]          cfg_wdata
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_MX    = 4'd1;
  localparam logic [3:0] ST_MO    = 4'd2;
  localparam logic [3:0] ST_SUM   = 4'd3;
  localparam logic [3:0] ST_NUM   = 4'd4;
  localparam logic [3:0] ST_DIV   = 4'd5;
  localparam logic [3:0] ST_FRESH = 4'd6;
  localparam logic [3:0] ST_USE   = 4'd7;
  localparam logic [3:0] ST_QF    = 4'd8;
  localparam logic [3:0] ST_ERR   = 4'd9;
  localparam logic [3:0] ST_GAIN  = 4'd10;
  localparam logic [3:0] ST_VEL   = 4'd11;
  localparam logic [3:0] ST_OUT   = 4'd12;

  // settings
  logic [31:0] gain_finger_r, gain_spread_r, tc_r, coupling_r;
  logic [30:0] limit_finger_r, limit_spread_r, deadzone_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_finger_r  <= RST_GAIN_FINGER;
      gain_spread_r  <= RST_GAIN_SPREAD;
      limit_finger_r <= RST_LIMIT_FINGER;
      limit_spread_r <= RST_LIMIT_SPREAD;
      tc_r           <= RST_TIME_CONST;
      deadzone_r     <= RST_DEADZONE;
      coupling_r     <= RST_COUPLING;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GAIN_FINGER:  gain_finger_r  <= cfg_wdata;
        CFG_GAIN_SPREAD:  gain_spread_r  <= cfg_wdata;
        CFG_LIMIT_FINGER: limit_finger_r <= cfg_wdata[30:0];
        CFG_LIMIT_SPREAD: limit_spread_r <= cfg_wdata[30:0];
        CFG_TIME_CONST:   tc_r           <= cfg_wdata;
        CFG_DEADZONE:     deadzone_r     <= cfg_wdata[30:0];
        CFG_COUPLING:     coupling_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic [3:0] state_r, state_nxt;

  // latched word and working values
  logic [1:0]         joint_r;
  logic [JIDX_W-1:0]  slot_r;
  logic signed [31:0] des_r, meas_r, old_r;
  logic [11:0]        xabs_r;
  logic               xneg_r;
  logic [31:0]        dt_r;
  logic [32:0]        den_r;
  logic               spread_r;
  logic [63:0]        xm_r, mag_r;
  logic               neg_r;
  logic signed [31:0] fresh_r, qf_r, e_r, vel_r;

  logic signed [31:0] fs_r [JOINTS];

  // output register
  logic               out_valid_r;
  logic [1:0]         out_joint_r;
  logic signed [31:0] out_vel_r, out_fresh_r;

  // shared units
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod_r;
  logic               div_start;
  logic [63:0]        div_num;
  logic               div_done;
  logic [63:0]        quo;

  slpl_mul u_mul (
    .clk    (clk),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .prod_r (prod_r)
  );

  slpl_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (den_r),
    .done_r   (div_done),
    .quo_r    (quo)
  );

  logic        accept;
  logic [12:0] xs;
  logic [12:0] xs_abs;
  logic [63:0] om;
  logic signed [31:0] fresh_nxt;
  logic        big;
  logic signed [32:0] dx, dz;
  logic signed [31:0] used_sel;
  logic signed [49:0] qround, vround, lim, err_w;
  logic signed [31:0] vel_nxt;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign xs       = {1'b0, in_strain_raw} - STRAIN_OFFSET;
  assign xs_abs   = xs[12] ? (13'd0 - xs) : xs;
  assign om       = prod_r[63:0];
  assign div_num  = mag_r + {32'd0, den_r[32:1]};
  assign div_start = (state_r == ST_NUM);

  // operand selection for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_MX: begin
        mul_a = signed'({5'd0, xabs_r, 16'd0});
        mul_b = signed'({1'b0, dt_r});
      end
      ST_MO: begin
        mul_a = old_r[31] ? (33'sd0 - {old_r[31], old_r}) : {old_r[31], old_r};
        mul_b = signed'({1'b0, tc_r});
      end
      ST_USE: begin
        mul_a = signed'({1'b0, coupling_r});
        mul_b = {used_sel[31], used_sel};
      end
      ST_GAIN: begin
        mul_a = signed'({1'b0, (spread_r ? gain_spread_r : gain_finger_r)});
        mul_b = {e_r[31], e_r};
      end
      default: ;
    endcase
  end

  // quotient limited to the signed 32-bit range
  assign big = |quo[63:31];
  always_comb begin
    if (den_r == 33'd0) begin
      fresh_nxt = old_r;
    end else if (neg_r) begin
      fresh_nxt = big ? 32'sh8000_0000 : signed'(32'd0 - quo[31:0]);
    end else begin
      fresh_nxt = big ? 32'sh7FFF_FFFF : signed'(quo[31:0]);
    end
  end

  // deadzone keeps the old value for small changes
  assign dx       = {fresh_r[31], fresh_r} - {old_r[31], old_r};
  assign dz       = signed'({2'b00, deadzone_r});
  assign used_sel = ((dx < dz) && (dx > -dz)) ? old_r : fresh_r;
  assign qround = round_q16(prod_r);
  assign err_w  = 50'(signed'({{2{des_r[31]}}, des_r}) - signed'({{2{meas_r[31]}}, meas_r})
                      - signed'({{2{qf_r[31]}}, qf_r}));
  assign vround = round_q16(prod_r);
  assign lim    = signed'({19'd0, (spread_r ? limit_spread_r : limit_finger_r)});

  always_comb begin
    if (vround > lim) begin
      vel_nxt = lim[31:0];
    end else if (vround < -lim) begin
      vel_nxt = 32'(-lim);
    end else begin
      vel_nxt = vround[31:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (accept) state_nxt = ST_MX;
      ST_MX:    state_nxt = ST_MO;
      ST_MO:    state_nxt = ST_SUM;
      ST_SUM:   state_nxt = (den_r == 33'd0) ? ST_FRESH : ST_NUM;
      ST_NUM:   state_nxt = ST_DIV;
      ST_DIV:   if (div_done) state_nxt = ST_FRESH;
      ST_FRESH: state_nxt = ST_USE;
      ST_USE:   state_nxt = ST_QF;
      ST_QF:    state_nxt = ST_ERR;
      ST_ERR:   state_nxt = ST_GAIN;
      ST_GAIN:  state_nxt = ST_VEL;
      ST_VEL:   state_nxt = ST_OUT;
      ST_OUT:   if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < JOINTS; i++) begin
        fs_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_FRESH) begin
        fs_r[slot_r] <= fresh_nxt;
      end
      if (state_r == ST_OUT && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      joint_r  <= in_joint;
      slot_r   <= slot_of(in_joint);
      des_r    <= in_desired_pos;
      meas_r   <= in_measured_pos;
      xabs_r   <= xs_abs[11:0];
      xneg_r   <= xs[12];
      dt_r     <= in_elapsed;
      den_r    <= {1'b0, tc_r} + {1'b0, in_elapsed};
      old_r    <= fs_r[slot_of(in_joint)];
      spread_r <= (in_joint == SPREAD_JOINT);
    end
    if (state_r == ST_MO) begin
      xm_r <= prod_r[63:0];
    end
    // combine the two terms in sign-magnitude
    if (state_r == ST_SUM) begin
      if (xneg_r == old_r[31]) begin
        neg_r <= xneg_r;
        mag_r <= xm_r + om;
      end else if (xm_r >= om) begin
        neg_r <= xneg_r;
        mag_r <= xm_r - om;
      end else begin
        neg_r <= old_r[31];
        mag_r <= om - xm_r;
      end
    end
    if (state_r == ST_FRESH) begin
      fresh_r <= fresh_nxt;
    end
    if (state_r == ST_QF) begin
      qf_r <= sat32(qround);
    end
    if (state_r == ST_ERR) begin
      e_r <= sat32(err_w);
    end
    if (state_r == ST_VEL) begin
      vel_r <= vel_nxt;
    end
    if (state_r == ST_OUT && (!out_valid_r || !out_stall)) begin
      out_joint_r <= joint_r;
      out_vel_r   <= vel_r;
      out_fresh_r <= fresh_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_joint_out       = out_joint_r;
  assign out_velocity_cmd    = out_vel_r;
  assign out_strain_filtered = out_fresh_r;

endmodule
`default_nettype wire
